// ===== rtl/core/binary_to_decimal_ascii_macros.svh =====
// assertion macros shared by the binary to decimal ascii checker
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// condition that must hold at every edge out of reset
`define BTDA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("btda check failed");

// condition that must hold in the cycle after a trigger
`define BTDA_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("btda check failed");

`endif

// ===== rtl/core/btda_pkg.sv =====
// shared types and constants of the binary to decimal ascii converter
package btda_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    // one converted value waiting to be emitted
    typedef struct packed {
        bcd_t             digits;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

// ===== rtl/core/btda_front.sv =====
// front end: accepts a binary value and converts it to bcd by shift-add-3
module btda_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     value_valid,
    output logic                     value_ready,
    input  logic [31:0]              value_in,
    output logic                     push_valid,
    input  logic                     push_ready,
    output btda_pkg::entry_t         push_data
);
    import btda_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SHIFT = 3'b010,
        F_PUSH  = 3'b100
    } front_state_t;

    localparam logic [BIT_CNT_W-1:0] SHIFT_LAST = BIT_CNT_W'(VALUE_W - 1);

    front_state_t                    state_reg, state_next;
    logic [BIT_CNT_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic [VALUE_W-1:0]              bin_reg, bin_next;
    bcd_t                            bcd_reg, bcd_next;
    bcd_t                            bcd_adj;
    logic [NUM_DIGITS*DIGIT_W-1:0]   bcd_adj_flat;
    logic [CNT_W-1:0]                num_digits;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // flat view of the adjusted digits for the one-bit shift
    assign bcd_adj_flat = bcd_adj;

    // significant digit count, at least one so that zero prints '0'
    always_comb
    begin
        num_digits = CNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != '0)
            begin
                num_digits = CNT_W'(i + 1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (value_valid)
                begin
                    bin_next     = value_in;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = F_SHIFT;
                end
            end
            F_SHIFT:
            begin
                bcd_next     = {bcd_adj_flat[NUM_DIGITS*DIGIT_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == SHIFT_LAST)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign value_ready      = (state_reg == F_IDLE);
    assign push_valid       = (state_reg == F_PUSH);
    assign push_data.digits = bcd_reg;
    assign push_data.count  = num_digits;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // conversion datapath
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ===== rtl/core/btda_queue.sv =====
// short fifo of converted values between front and back end
module btda_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  btda_pkg::entry_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output btda_pkg::entry_t  pop_data
);
    import btda_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    entry_t              mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign push_ready = (fill_reg != FILL_MAX);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/btda_back.sv =====
// back end: emits the bcd digits as ascii, most significant first
module btda_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  btda_pkg::entry_t            pop_data,
    output logic                        digit_valid,
    input  logic                        digit_ready,
    output logic [btda_pkg::CHAR_W-1:0] digit_char,
    output logic                        last_digit
);
    import btda_pkg::*;

    typedef enum logic [1:0] {
        B_LOAD = 2'b01,
        B_EMIT = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    bcd_t                digits_reg, digits_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic                can_emit;

    assign can_emit    = !out_valid_reg || digit_ready;
    assign pop_ready   = (state_reg == B_LOAD);
    assign digit_valid = out_valid_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;

    // emit sequencer with output register
    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (digit_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_LOAD:
            begin
                if (pop_valid)
                begin
                    digits_next = pop_data.digits;
                    idx_next    = pop_data.count - 1'b1;
                    state_next  = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + {2'b00, digits_reg[idx_reg]};
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = B_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_LOAD;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // digit and output payload
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// top level of the binary to decimal ascii converter
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------
//  value   | value_valid / value_ready  | value_in[31:0]
//  digit   | digit_valid / digit_ready  | digit_char[5:0], last_digit
//
// the front end loads a value, runs 32 shift-add-3 steps, then pushes the result
// the back end loads an entry, then emits its 1 to 10 digits, one per cycle unless stalled
// front and back overlap through the queue, so the front converts while the back emits
// reset clears the sequencers, the queue and the output valid; no data is kept across values
// a stalled digit output holds the back end; the front keeps converting until the queue fills
module binary_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_ready,
    input  logic [31:0] value_in,
    output logic        digit_valid,
    input  logic        digit_ready,
    output logic [5:0]  digit_char,
    output logic        last_digit
);
    import btda_pkg::*;

    logic    push_valid, push_ready;
    entry_t  push_data;
    logic    pop_valid, pop_ready;
    entry_t  pop_data;

    // value conversion
    btda_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value_in    (value_in),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // decoupling queue
    btda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // digit emission
    btda_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

endmodule

// ===== rtl/core/btda_checker.sv =====
// port-level checks of the binary to decimal ascii converter and their bind
`include "binary_to_decimal_ascii_macros.svh"

module btda_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    input  logic        value_ready,
    input  logic        digit_valid,
    input  logic        digit_ready,
    input  logic [5:0]  digit_char,
    input  logic        last_digit
);
    import btda_pkg::*;

    logic first_reg, first_next;
    logic digit_xfer;

    assign digit_xfer = digit_valid && digit_ready;

    // marks that the next digit transfer opens a new number
    always_comb
    begin
        first_next = first_reg;
        if (digit_xfer)
        begin
            first_next = last_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

    // a value transfer starts a conversion, so the input is busy next cycle
    `BTDA_ASSERT_NEXT(a_value_busy, clk, rst_n, value_valid && value_ready, !value_ready)

    // a stalled digit keeps its character and mark
    `BTDA_ASSERT_NEXT(a_digit_hold, clk, rst_n, digit_valid && !digit_ready, digit_valid && $stable(digit_char) && $stable(last_digit))

    // every character is an ascii decimal digit
    `BTDA_ASSERT_ALWAYS(a_digit_range, clk, rst_n, !digit_valid || (digit_char >= ASCII_ZERO && digit_char <= 6'd57))

    // a number of more than one digit never opens with a zero
    `BTDA_ASSERT_ALWAYS(a_no_lead_zero, clk, rst_n, !(digit_xfer && first_reg && !last_digit) || (digit_char != ASCII_ZERO))

endmodule

bind binary_to_decimal_ascii btda_checker u_btda_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .digit_valid (digit_valid),
    .digit_ready (digit_ready),
    .digit_char  (digit_char),
    .last_digit  (last_digit)
);

// ===== dv/testbench.sv =====
// self-checking testbench of the binary to decimal ascii converter
module testbench;

    import btda_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int DECIMAL_BASE   = 10;
    localparam int RANDOM_PER_PHASE = 55;
    localparam int DRAIN_CYCLES   = 100;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DIRECTED_ROWS  = 17;

    // one expected character of the digit stream
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_entry_t;

    logic              clk;
    logic              rst_n;
    logic              value_valid;
    logic              value_ready;
    logic [VALUE_W-1:0] value_in;
    logic              digit_valid;
    logic              digit_ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    digit_entry_t expected_digits [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    // directed values; an empty text means the predictor supplies the digits
    logic [VALUE_W-1:0] directed_value [DIRECTED_ROWS] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
        32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4294967294,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd1234567890, 32'd3000000000
    };
    string directed_text [DIRECTED_ROWS] = '{
        "0", "1", "9", "10", "99", "", "",
        "999999999", "1000000000", "4294967295", "4294967294",
        "", "", "", "", "", ""
    };

    binary_to_decimal_ascii uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value_in    (value_in),
        .digit_valid (digit_valid),
        .digit_ready (digit_ready),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("CHECK FAILED");
        $finish;
    end

    // decimal digits of a value, most significant first, pushed as expectations
    task automatic queue_expected_digits(input logic [VALUE_W-1:0] v);
        logic [DIGIT_W-1:0] reversed [NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        digit_entry_t       e;
        int                 count;
        int                 k;
        rest  = v;
        count = 0;
        do
        begin
            reversed[count] = DIGIT_W'(rest % DECIMAL_BASE);
            rest            = rest / DECIMAL_BASE;
            count++;
        end
        while (rest != 0 && count < NUM_DIGITS);
        for (k = 0; k < count; k++)
        begin
            e.ch   = ASCII_ZERO + CHAR_W'(reversed[count - 1 - k]);
            e.last = (k == count - 1);
            expected_digits.push_back(e);
        end
    endtask

    // random value: mostly by digit count, some fully random, some at or just below powers of ten
    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        int          n;
        int          i;
        int          mode;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            return $urandom;
        n  = $urandom_range(1, NUM_DIGITS);
        lo = 64'd1;
        for (i = 1; i < n; i++)
            lo = lo * DECIMAL_BASE;
        if (mode == 2)
            return (lo == 64'd1 || $urandom_range(0, 1)) ? lo[VALUE_W-1:0] : VALUE_W'(lo - 1);
        hi = lo * DECIMAL_BASE - 1;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        if (n == 1)
            lo = 64'd0;
        span = hi - lo + 1;
        return VALUE_W'(lo + ({32'd0, $urandom} % span));
    endfunction

    // present one value and hold it until the transfer
    task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
        digit_entry_t e;
        byte          c;
        int           i;
        value_valid <= 1'b1;
        value_in    <= v;
        @(posedge clk);
        while (!value_ready)
            @(posedge clk);
        if (text.len() == 0)
            queue_expected_digits(v);
        else
            for (i = 0; i < text.len(); i++)
            begin
                c      = text[i];
                e.ch   = c[CHAR_W-1:0];
                e.last = (i == text.len() - 1);
                expected_digits.push_back(e);
            end
    endtask

    // random gap on the value side
    task automatic sender_gap();
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // digit side: check every transfer, then pick the next ready
    always @(posedge clk)
    begin
        digit_entry_t e;
        if (rst_n && digit_valid && digit_ready)
        begin
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected digit transfer, expected none, got char %0d last %0b",
                         $time, digit_char, last_digit);
                error_count++;
            end
            else
            begin
                e = expected_digits.pop_front();
                if (digit_char !== e.ch)
                begin
                    $display("%0t: digit_char expected %0d got %0d", $time, e.ch, digit_char);
                    error_count++;
                end
                if (last_digit !== e.last)
                begin
                    $display("%0t: last_digit expected %0b got %0b", $time, e.last, last_digit);
                    error_count++;
                end
            end
        end
        digit_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // stimulus
    initial
    begin
        int phase;
        int row;
        int n;
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n       <= 1'b0;
        value_valid <= 1'b0;
        value_in    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            // directed rows first
            if (phase == 0)
                for (row = 0; row < DIRECTED_ROWS; row++)
                begin
                    sender_gap();
                    send_value(directed_value[row], directed_text[row]);
                end

            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                sender_gap();
                send_value(random_value(), "");
            end

            // hold off until the digit stream has drained
            value_valid <= 1'b0;
            while (expected_digits.size() != 0)
                @(posedge clk);
        end

        // let any stray digits show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/btda_pkg.sv
rtl/core/btda_front.sv
rtl/core/btda_queue.sv
rtl/core/btda_back.sv
rtl/core/binary_to_decimal_ascii.sv
rtl/core/btda_checker.sv
dv/testbench.sv
